// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: sv/isort_pkg.sv
// Shared constants and controller/datapath interface types of the insertion sorter.
package isort_pkg;

	// Default capacity of the sorted store, in elements.
	localparam int MAX_ITEMS_DEF = 64;

	// Width of one element.
	localparam int DATA_W = 32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic insert;      // place the incoming value into the store
		logic mark_drop;   // store is full: record that the value was lost
		logic shift;       // one result taken: move the store down by one
		logic clear_drop;  // batch finished: clear the sticky drop flag
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;        // store holds its capacity
		logic one_left;    // exactly one element remains
	} sts_t;

endpackage

// File: sv/isort_datapath.sv
// Row of compare-and-shift cells holding the sorted store, its fill count and drop flag.
module isort_datapath #(
	parameter int MaxItems = isort_pkg::MAX_ITEMS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  isort_pkg::cmd_t                        cmd,
	output isort_pkg::sts_t                        sts,
	input  logic signed [isort_pkg::DATA_W-1:0]    value,
	output logic signed [isort_pkg::DATA_W-1:0]    value_res,
	output logic                                   dropped
);

	localparam int CNT_W = $clog2(MaxItems + 1);

	logic signed [isort_pkg::DATA_W-1:0] cells_q [MaxItems];
	logic        [CNT_W-1:0]             count_q;
	logic                                drop_q;
	logic        [MaxItems-1:0]          gt;

	// Each occupied cell compares its value with the incoming one. As the store is
	// sorted, the greater-than flags form a run of ones up to the fill count.
	for (genvar i = 0; i < MaxItems; i++) begin : g_cmp
		assign gt[i] = (CNT_W'(i) < count_q) && (cells_q[i] > value);
	end

	// Cell update: on insertion, cells past the insertion point take their lower
	// neighbour and the first greater cell (or the first free one) takes the value.
	// On a shift, every cell but the top one takes its upper neighbour.
	for (genvar i = 0; i < MaxItems; i++) begin : g_cell
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (cmd.insert) begin
					if (gt[i] || (count_q == CNT_W'(i))) begin
						cells_q[i] <= value;
					end
				end else if (cmd.shift) begin
					if (MaxItems > 1) begin
						cells_q[i] <= cells_q[(i + 1) % MaxItems];
					end
				end
			end
		end else if (i == MaxItems - 1) begin : g_top
			always_ff @(posedge clk) begin
				if (cmd.insert) begin
					if (gt[i-1]) begin
						cells_q[i] <= cells_q[i-1];
					end else if (gt[i] || (count_q == CNT_W'(i))) begin
						cells_q[i] <= value;
					end
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (cmd.insert) begin
					if (gt[i-1]) begin
						cells_q[i] <= cells_q[i-1];
					end else if (gt[i] || (count_q == CNT_W'(i))) begin
						cells_q[i] <= value;
					end
				end else if (cmd.shift) begin
					cells_q[i] <= cells_q[i+1];
				end
			end
		end
	end

	// Fill count: up on insertion, down as each result leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.shift) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// Sticky drop flag for the current batch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b0;
		end else if (cmd.mark_drop) begin
			drop_q <= 1'b1;
		end else if (cmd.clear_drop) begin
			drop_q <= 1'b0;
		end
	end

	// Status and results: the smallest element always sits in the first cell.
	always_comb begin
		sts.full     = (count_q == CNT_W'(MaxItems));
		sts.one_left = (count_q == CNT_W'(1));
	end

	assign value_res = cells_q[0];
	assign dropped   = drop_q;

endmodule

// File: sv/isort_ctrl.sv
// Controller state machine: collects a batch, then streams it out.
module isort_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            last,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            last_res,
	output isort_pkg::cmd_t cmd,
	input  isort_pkg::sts_t sts
);

	localparam logic ST_FILL = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic state_d;
	logic in_acc;
	logic out_acc;

	assign in_ready  = (state_q == ST_FILL);
	assign out_valid = (state_q == ST_EMIT);
	assign last_res  = out_valid && sts.one_left;
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	// Datapath commands for the current cycle.
	always_comb begin
		cmd.insert     = in_acc && !sts.full;
		cmd.mark_drop  = in_acc && sts.full;
		cmd.shift      = out_acc;
		cmd.clear_drop = out_acc && sts.one_left;
	end

	// Next state: a final request starts emission, the final result ends it.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FILL: begin
				if (in_acc && last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_acc && sts.one_left) begin
					state_d = ST_FILL;
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: sv/insertion_sorter.sv
// Insertion sorter: while collecting a batch, accepts one signed 32-bit request per cycle
// into a row of MaxItems compare-and-shift cells, each cell comparing with the incoming
// value in parallel, so an element is placed without a search. The request marked last
// ends the batch; the block then stops taking requests and streams the batch out in
// ascending order from the first cell, one result per cycle while out_ready is high,
// flagging the greatest with last_res. The next batch is accepted from the cycle after
// its final result leaves.
// Elements beyond MaxItems are discarded and dropped is set on every result of that batch.
module insertion_sorter #(
	parameter int MaxItems = isort_pkg::MAX_ITEMS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [isort_pkg::DATA_W-1:0] value,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [isort_pkg::DATA_W-1:0] value_res,
	output logic                                last_res,
	output logic                                dropped
);

	isort_pkg::cmd_t cmd;
	isort_pkg::sts_t sts;

	// Batch sequencing.
	isort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.last_res  (last_res),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Sorted store.
	isort_datapath #(
		.MaxItems (MaxItems)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.value_res (value_res),
		.dropped   (dropped)
	);

endmodule

// File: sv/insertion_sorter_checker.sv
// Port-level checker for the insertion sorter, bound to the top level.
`include "assert_macros.svh"

module insertion_sorter_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                last,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [isort_pkg::DATA_W-1:0] value_res,
	input logic                                last_res,
	input logic                                dropped
);

	logic out_stall;

	assign out_stall = out_valid && !out_ready;

	// A stalled result holds its value and flags.
	`ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable({value_res, last_res, dropped}))

	// No request is taken while a batch is being emitted.
	`ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready)

	// A final request starts emission in the following cycle.
	`ASSERT_NXT(a_emit_start, clk, arst_n, in_valid && in_ready && last, out_valid)

	// Emission stops once the final result has been taken.
	`ASSERT_NXT(a_emit_end, clk, arst_n, out_valid && out_ready && last_res, !out_valid && in_ready)

endmodule

bind insertion_sorter insertion_sorter_checker u_checker (.*);

// File: dv/insertion_sorter_tb.sv
// Self-checking testbench of the insertion sorter: batches in, sorted streams checked out.
module insertion_sorter_tb;

	typedef logic signed [isort_pkg::DATA_W-1:0] elem_t;

	localparam int CAPACITY    = isort_pkg::MAX_ITEMS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 2 * CAPACITY;

	// One sorted element as it should leave the block.
	typedef struct {
		elem_t value_res;
		logic  last_res;
		logic  dropped;
	} sorted_elem_t;

	// Keeps its own sorted copy of the current batch and the queue of elements due out.
	class sort_scoreboard;
		elem_t        batch_store[$];
		bit           drop_seen;
		int           capacity;
		sorted_elem_t sorted_due[$];
		int           errors;
		int           batches;
		int           results;
		int           dropped_results;

		function new(int cap);
			capacity = cap;
			drop_seen = 0;
			errors = 0;
			batches = 0;
			results = 0;
			dropped_results = 0;
		endfunction

		// Insert an accepted request and, at the end of a batch, queue the sorted stream.
		function void note_request(elem_t v, logic l);
			int pos;
			sorted_elem_t e;
			if (batch_store.size() >= capacity) begin
				drop_seen = 1;
			end else begin
				pos = 0;
				while (pos < batch_store.size() && !(batch_store[pos] > v))
					pos++;
				batch_store.insert(pos, v);
			end
			if (l) begin
				foreach (batch_store[k]) begin
					e.value_res = batch_store[k];
					e.last_res = (k == batch_store.size() - 1);
					e.dropped = drop_seen;
					sorted_due.push_back(e);
				end
				batch_store.delete();
				drop_seen = 0;
				batches++;
			end
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		// Compare one result with the oldest element still due.
		task check_result(elem_t v, logic l, logic d);
			sorted_elem_t e;
			if (sorted_due.size() == 0) begin
				report($sformatf("result %0d arrived with nothing due", v));
			end else begin
				e = sorted_due.pop_front();
				results++;
				if (e.dropped)
					dropped_results++;
				if (v !== e.value_res)
					report($sformatf("value_res %0d, wanted %0d", v, e.value_res));
				if (l !== e.last_res)
					report($sformatf("last_res %b, wanted %b", l, e.last_res));
				if (d !== e.dropped)
					report($sformatf("dropped %b, wanted %b", d, e.dropped));
			end
		endtask

		function int pending();
			return sorted_due.size();
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	elem_t value;
	logic  last;
	logic  out_valid;
	logic  out_ready;
	elem_t value_res;
	logic  last_res;
	logic  dropped;

	bit             steady;
	sort_scoreboard sb;

	insertion_sorter uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value_res(value_res),
		.last_res(last_res),
		.dropped(dropped)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long, never during a steady stretch.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Values lean towards the extremes and a narrow band, so that ties are frequent.
	function automatic elem_t pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 5))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h8000_0001;
				3: return 32'h7FFF_FFFE;
				4: return 32'hFFFF_FFFF;
				default: return 32'h0;
			endcase
		end else if (r < 4) begin
			return elem_t'($urandom_range(0, 8)) - 4;
		end
		return elem_t'($urandom);
	endfunction

	// Offer one request after a random gap and hold it until it is taken.
	task automatic send_request(elem_t v, logic l);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		value <= v;
		last <= l;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random_batch(int size);
		for (int i = 0; i < size; i++)
			send_request(pick_value(), i == size - 1);
	endtask

	// Back-pressure on the result side.
	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			n = pick_gap();
			repeat (n) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			n = $urandom_range(1, 8);
			repeat (n) begin
				@(negedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// Both handshakes are observed here, requests first.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(value, last);
			if (out_valid && out_ready)
				sb.check_result(value_res, last_res, dropped);
		end
	end

	// Watchdog.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int sent;
		int size;
		int over_at;
		bit over_done;
		sb = new(CAPACITY);
		steady = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		last = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: single-element batches at both extremes.
		send_request(32'h8000_0000, 1'b1);
		send_request(32'h7FFF_FFFF, 1'b1);
		// Descending arrival, so every value goes to the front of the store.
		send_request(32'h7FFF_FFFF, 1'b0);
		send_request(1, 1'b0);
		send_request(0, 1'b0);
		send_request(-1, 1'b0);
		send_request(32'h8000_0000, 1'b1);
		// Equal values kept together.
		send_request(5, 1'b0);
		send_request(5, 1'b0);
		send_request(-3, 1'b0);
		send_request(5, 1'b0);
		send_request(-3, 1'b1);
		// Ascending arrival: each value is appended.
		send_request(-2, 1'b0);
		send_request(-1, 1'b0);
		send_request(0, 1'b1);
		// Pairs whose difference would overflow a subtracting compare.
		send_request(32'h7FFF_FFFE, 1'b0);
		send_request(32'h8000_0001, 1'b0);
		send_request(32'h7FFF_FFFF, 1'b0);
		send_request(32'h8000_0000, 1'b1);

		// Random batches, mostly small; one fills the store and then overflows it.
		sent = 0;
		over_done = 0;
		over_at = $urandom_range(0, 40);
		while (sent < 110 || !over_done) begin
			steady = ($urandom_range(0, 4) == 0);
			if (!over_done && sent >= over_at) begin
				size = CAPACITY + $urandom_range(1, 3);
				over_done = 1;
			end else begin
				case ($urandom_range(0, 19))
					0: size = $urandom_range(13, 30);
					1, 2, 3, 4, 5: size = $urandom_range(5, 12);
					default: size = $urandom_range(1, 4);
				endcase
			end
			send_random_batch(size);
			sent += size;
		end
		steady = 0;
		@(negedge clk);
		in_valid <= 1'b0;

		// Drain, then give any stray result time to show up.
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sorted %0d batches, %0d directed and %0d random requests.",
			sb.batches, 19, sent);
		$display("Checked %0d results, %0d of them from the batch that overflowed the store.",
			sb.results, sb.dropped_results);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/isort_pkg.sv
sv/isort_datapath.sv
sv/isort_ctrl.sv
sv/insertion_sorter.sv
sv/insertion_sorter_checker.sv
dv/insertion_sorter_tb.sv
